### src/tcte_pkg.sv
// ----------------------------------------------------------------------------
// TCP connection table engine package
// Shared types, codes and constants of the connection table engine.
// ----------------------------------------------------------------------------
package tcte_pkg;

  localparam int ENTRIES_DEF = 16;

  localparam logic [2:0] CMD_SEGMENT = 3'd0;
  localparam logic [2:0] CMD_CONNECT = 3'd1;
  localparam logic [2:0] CMD_LISTEN  = 3'd2;
  localparam logic [2:0] CMD_CLOSE   = 3'd3;
  localparam logic [2:0] CMD_SEND    = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_NO_ENTRY  = 3'd2;
  localparam logic [2:0] ST_NOT_ESTAB = 3'd3;
  localparam logic [2:0] ST_SHORT     = 3'd4;

  localparam logic [2:0] PH_CLOSED     = 3'd0;
  localparam logic [2:0] PH_LISTEN     = 3'd1;
  localparam logic [2:0] PH_SYN_SENT   = 3'd2;
  localparam logic [2:0] PH_SYN_RCVD   = 3'd3;
  localparam logic [2:0] PH_ESTAB      = 3'd4;
  localparam logic [2:0] PH_CLOSE_WAIT = 3'd5;
  localparam logic [2:0] PH_FIN_WAIT1  = 3'd6;

  localparam logic [7:0] FL_FIN = 8'h01;
  localparam logic [7:0] FL_SYN = 8'h02;
  localparam logic [7:0] FL_PSH = 8'h08;
  localparam logic [7:0] FL_ACK = 8'h10;

  localparam logic [1:0] REG_LOCAL_IP    = 2'd0;
  localparam logic [1:0] REG_ACTIVE_SEQ  = 2'd1;
  localparam logic [1:0] REG_PASSIVE_SEQ = 2'd2;

  localparam logic [15:0] EPHEMERAL_BASE = 16'd49152;
  localparam logic [15:0] MIN_SEG_LEN    = 16'd20;
  localparam logic [31:0] ACTIVE_SEQ_RST  = 32'd1000;
  localparam logic [31:0] PASSIVE_SEQ_RST = 32'd2000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  slot;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [15:0] host_port;
    logic [31:0] seq_num;
    logic [7:0]  seg_flags;
    logic [3:0]  header_words;
    logic [15:0] seg_len;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot_out;
    logic [2:0]  conn_state;
    logic        tx_valid;
    logic [7:0]  tx_flags;
    logic [31:0] tx_seq;
    logic [31:0] tx_ack;
    logic [15:0] tx_src_port;
    logic [15:0] tx_dest_port;
    logic [31:0] tx_remote_ip;
  } out_item_t;

  // Wide fields of one entry, kept in the memory.
  typedef struct packed {
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
    logic [15:0] own_port;
    logic [31:0] send_seq;
    logic [31:0] recv_ack;
  } entry_t;

endpackage

### src/tcte_match.sv
// ----------------------------------------------------------------------------
// Connection key match
// Compares a segment key against every entry's key and picks the slot, then
// finds the lowest free entry for allocation.
// ----------------------------------------------------------------------------
module tcte_match #(
  parameter int ENTRIES = tcte_pkg::ENTRIES_DEF,
  parameter int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic [ENTRIES-1:0]       used,
  input  logic [ENTRIES-1:0][2:0]  phase,
  input  logic [ENTRIES-1:0][31:0] key_addr,
  input  logic [ENTRIES-1:0][15:0] key_rport,
  input  logic [ENTRIES-1:0][15:0] key_lport,
  input  logic [31:0]              rip,
  input  logic [15:0]              rport,
  input  logic [15:0]              lport,
  output logic                     hit,
  output logic [IW-1:0]            hit_idx,
  output logic                     free_ok,
  output logic [IW-1:0]            free_idx
);
  logic [ENTRIES-1:0] full_m, lis_m;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      full_m[i] = used[i] && key_addr[i] == rip && key_rport[i] == rport &&
                  key_lport[i] == lport;
      lis_m[i]  = used[i] && phase[i] == tcte_pkg::PH_LISTEN && key_lport[i] == lport;
    end
  end

  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (lis_m[i]) begin
        hit = 1'b1;
        hit_idx = IW'(i);
      end
    end
    // A full key match wins over any listener.
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (full_m[i]) begin
        hit = 1'b1;
        hit_idx = IW'(i);
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (full_m[i]) hit = 1'b1;
    end
  end

  always_comb begin
    free_ok = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_ok = 1'b1;
        free_idx = IW'(i);
      end
    end
  end
endmodule

### src/tcp_connection_table_engine_top.sv
// ----------------------------------------------------------------------------
// TCP connection table engine
// Keeps a table of connection entries and runs a simplified TCP state
// machine on commands and received segment headers.
// ----------------------------------------------------------------------------
// Input transactions carry a command or a received segment header; each
// command 0..4 yields exactly one result transaction on the out_ channel,
// and commands 5..7 are dropped without a result.
// An item is taken in, its entry is read from the entry memory into a register
// in the read state, modified and written back in the modify state, where the
// result is registered. A new item is accepted in the cycle after the
// write-back, so the engine takes no new item before it is through with the
// last one; the read-modify-write of the entry memory sets this pace.
// Keys (address, ports), used bits and phases are also held in flip-flops
// so that segment lookup compares all entries in parallel.
// When the receiver stalls, the result is held in the output register and
// the modify step of the next item waits until that register is free.
// Reset frees every entry and restores the register defaults; the wide
// entry fields need no clearing since allocation rewrites them.
// ----------------------------------------------------------------------------
module tcp_connection_table_engine_top #(
  parameter int ENTRIES = tcte_pkg::ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tcte_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tcte_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_MOD  = 2'd2;

  logic [1:0] state_r;
  tcte_pkg::in_item_t item_r;
  logic [31:0] local_ip_r, act_seq_r, pas_seq_r;

  logic [ENTRIES-1:0]       used_r;
  logic [ENTRIES-1:0][2:0]  phase_r;
  logic [ENTRIES-1:0][31:0] kaddr_r;
  logic [ENTRIES-1:0][15:0] krport_r, klport_r;

  tcte_pkg::entry_t mem [ENTRIES];
  tcte_pkg::entry_t rd_r;
  logic [IW-1:0] idx_r;
  logic          hit_r, free_r, inrange_r;

  logic hit, free_ok;
  logic [IW-1:0] hit_idx, free_idx;
  logic accept;
  logic mod_go;

  tcte_match #(.ENTRIES(ENTRIES), .IW(IW)) u_match (
    .used(used_r), .phase(phase_r), .key_addr(kaddr_r), .key_rport(krport_r),
    .key_lport(klport_r), .rip(item_r.peer_ip), .rport(item_r.peer_port),
    .lport(item_r.host_port), .hit(hit), .hit_idx(hit_idx),
    .free_ok(free_ok), .free_idx(free_idx)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept = in_valid && !in_stall;
  // The modify step completes only when the output register can take its result.
  assign mod_go = (state_r == S_MOD) && !(out_valid && out_stall);

  logic [IW-1:0] sel_idx;
  logic in_range;
  always_comb begin
    in_range = ({28'b0, item_r.slot} < 32'(ENTRIES));
    case (item_r.cmd)
      tcte_pkg::CMD_SEGMENT: sel_idx = hit_idx;
      tcte_pkg::CMD_CONNECT, tcte_pkg::CMD_LISTEN: sel_idx = free_idx;
      default: sel_idx = IW'(item_r.slot);
    endcase
  end

  // Modify step.
  tcte_pkg::entry_t  wr;
  tcte_pkg::out_item_t res;
  logic        do_wr, do_out;
  logic [2:0]  ph, ph_new;
  logic        used_new;
  logic [15:0] dlen;

  always_comb begin
    wr = rd_r;
    res = '0;
    do_wr = 1'b0;
    do_out = 1'b1;
    ph = phase_r[idx_r];
    ph_new = ph;
    used_new = used_r[idx_r];
    dlen = item_r.seg_len - {10'b0, item_r.header_words, 2'b0};
    case (item_r.cmd)
      tcte_pkg::CMD_SEGMENT: begin
        if (item_r.seg_len < tcte_pkg::MIN_SEG_LEN) begin
          res.status = tcte_pkg::ST_SHORT;
        end else if (!hit_r) begin
          res.status = tcte_pkg::ST_NO_ENTRY;
        end else begin
          case (ph)
            tcte_pkg::PH_LISTEN: begin
              if (item_r.seg_flags[1]) begin
                wr.peer_addr = item_r.peer_ip;
                wr.peer_port = item_r.peer_port;
                wr.recv_ack = item_r.seq_num + 32'd1;
                wr.send_seq = pas_seq_r;
                ph_new = tcte_pkg::PH_SYN_RCVD;
                res.tx_valid = 1'b1;
                res.tx_flags = tcte_pkg::FL_SYN | tcte_pkg::FL_ACK;
                res.tx_seq = pas_seq_r;
                wr.send_seq = pas_seq_r + 32'd1;
              end
            end
            tcte_pkg::PH_SYN_SENT: begin
              if (item_r.seg_flags[1] && item_r.seg_flags[4]) begin
                wr.recv_ack = item_r.seq_num + 32'd1;
                ph_new = tcte_pkg::PH_ESTAB;
                res.tx_valid = 1'b1;
                res.tx_flags = tcte_pkg::FL_ACK;
                res.tx_seq = rd_r.send_seq;
              end
            end
            tcte_pkg::PH_SYN_RCVD: begin
              if (item_r.seg_flags[4]) ph_new = tcte_pkg::PH_ESTAB;
            end
            tcte_pkg::PH_ESTAB: begin
              if (item_r.seg_flags[0]) begin
                wr.recv_ack = item_r.seq_num + 32'd1;
                res.tx_valid = 1'b1;
                res.tx_flags = tcte_pkg::FL_ACK;
                res.tx_seq = rd_r.send_seq;
                ph_new = tcte_pkg::PH_CLOSE_WAIT;
              end else if (item_r.seg_flags[4] && dlen != 16'd0) begin
                wr.recv_ack = item_r.seq_num + {16'b0, dlen};
                res.tx_valid = 1'b1;
                res.tx_flags = tcte_pkg::FL_ACK;
                res.tx_seq = rd_r.send_seq;
              end
            end
            default: ;
          endcase
          do_wr = 1'b1;
          res.status = tcte_pkg::ST_OK;
          res.slot_out = 4'(idx_r);
          res.conn_state = ph_new;
        end
      end
      tcte_pkg::CMD_CONNECT, tcte_pkg::CMD_LISTEN: begin
        if (!free_r) begin
          res.status = tcte_pkg::ST_FULL;
        end else begin
          do_wr = 1'b1;
          used_new = 1'b1;
          wr = '0;
          if (item_r.cmd == tcte_pkg::CMD_CONNECT) begin
            wr.peer_addr = item_r.peer_ip;
            wr.peer_port = item_r.peer_port;
            wr.own_port = tcte_pkg::EPHEMERAL_BASE | {2'b0, item_r.peer_port[13:0]};
            wr.send_seq = act_seq_r + 32'd1;
            ph_new = tcte_pkg::PH_SYN_SENT;
            res.tx_valid = 1'b1;
            res.tx_flags = tcte_pkg::FL_SYN;
            res.tx_seq = act_seq_r;
          end else begin
            wr.own_port = item_r.host_port;
            ph_new = tcte_pkg::PH_LISTEN;
          end
          res.slot_out = 4'(idx_r);
          res.conn_state = ph_new;
        end
      end
      tcte_pkg::CMD_CLOSE: begin
        if (!inrange_r) begin
          res.status = tcte_pkg::ST_NO_ENTRY;
          res.slot_out = item_r.slot;
        end else begin
          do_wr = 1'b1;
          used_new = 1'b0;
          if (ph == tcte_pkg::PH_ESTAB) begin
            res.tx_valid = 1'b1;
            res.tx_flags = tcte_pkg::FL_FIN | tcte_pkg::FL_ACK;
            res.tx_seq = rd_r.send_seq;
            ph_new = tcte_pkg::PH_FIN_WAIT1;
          end
          res.slot_out = 4'(idx_r);
          res.conn_state = ph_new;
        end
      end
      tcte_pkg::CMD_SEND: begin
        if (!inrange_r) begin
          res.status = tcte_pkg::ST_NO_ENTRY;
          res.slot_out = item_r.slot;
        end else if (ph != tcte_pkg::PH_ESTAB) begin
          res.status = tcte_pkg::ST_NOT_ESTAB;
          res.slot_out = 4'(idx_r);
          res.conn_state = ph;
        end else begin
          do_wr = 1'b1;
          res.tx_valid = 1'b1;
          res.tx_flags = tcte_pkg::FL_ACK | tcte_pkg::FL_PSH;
          res.tx_seq = rd_r.send_seq;
          wr.send_seq = rd_r.send_seq + {16'b0, item_r.seg_len};
          res.slot_out = 4'(idx_r);
          res.conn_state = ph;
        end
      end
      default: do_out = 1'b0;
    endcase
    if (res.tx_valid) begin
      res.tx_ack = wr.recv_ack;
      res.tx_src_port = wr.own_port;
      res.tx_dest_port = wr.peer_port;
      res.tx_remote_ip = wr.peer_addr;
    end
  end

  // The local address register is stored but has no bearing on any result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
      used_r <= '0;
      phase_r <= '0;
      local_ip_r <= '0;
      act_seq_r <= tcte_pkg::ACTIVE_SEQ_RST;
      pas_seq_r <= tcte_pkg::PASSIVE_SEQ_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tcte_pkg::REG_LOCAL_IP:    local_ip_r <= cfg_data;
          tcte_pkg::REG_ACTIVE_SEQ:  act_seq_r <= cfg_data;
          tcte_pkg::REG_PASSIVE_SEQ: pas_seq_r <= cfg_data;
          default: ;
        endcase
      end
      out_valid <= (out_valid && out_stall) || (mod_go && do_out);
      case (state_r)
        S_IDLE: if (accept) state_r <= S_READ;
        S_READ: state_r <= S_MOD;
        S_MOD: begin
          if (mod_go) begin
            state_r <= S_IDLE;
            if (do_wr) begin
              used_r[idx_r] <= used_new;
              phase_r[idx_r] <= ph_new;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item_r <= in_data;
    if (state_r == S_READ) begin
      rd_r <= mem[sel_idx];
      idx_r <= sel_idx;
      hit_r <= hit;
      free_r <= free_ok;
      inrange_r <= in_range;
    end
    if (mod_go) begin
      if (do_out) out_data <= res;
      if (do_wr) begin
        mem[idx_r] <= wr;
        kaddr_r[idx_r] <= wr.peer_addr;
        krport_r[idx_r] <= wr.peer_port;
        klport_r[idx_r] <= wr.own_port;
      end
    end
  end
endmodule
